// File: hw/rtl/bc45_pkg.sv
// ----------------------------------------------------------------------------
// BC4/BC5 texel decode package
// Shared widths, decode constants, index codes and the configuration struct.
// ----------------------------------------------------------------------------
package bc45_pkg;

   // Block layout
   localparam int BLOCK_WIDTH    = 64;
   localparam int ENDPOINT_WIDTH = 8;
   localparam int INDEX_WIDTH    = 3;
   localparam int TEXEL_COUNT    = 16;
   localparam int COORD_WIDTH    = 2;
   localparam int VALUE_WIDTH    = 16;

   // Blend arithmetic: sum of weighted endpoints, scaled numerator, reciprocal
   localparam int SUM_WIDTH    = 11;
   localparam int SCALED_WIDTH = 20;
   localparam int RECIP_WIDTH  = 21;
   localparam int RECIP_SHIFT  = 24;
   localparam int PROD_WIDTH   = SCALED_WIDTH + RECIP_WIDTH;

   // 2 * 257: numerator doubled for round-half-up
   localparam logic [SCALED_WIDTH-1:0] BLEND_SCALE = SCALED_WIDTH'(514);
   localparam logic [SCALED_WIDTH-1:0] DIV_SEVEN   = SCALED_WIDTH'(7);
   localparam logic [SCALED_WIDTH-1:0] DIV_FIVE    = SCALED_WIDTH'(5);
   // ceil(2^24 / 14) and ceil(2^24 / 10): exact floor division below 2^20
   localparam logic [RECIP_WIDTH-1:0]  RECIP_SEVEN = RECIP_WIDTH'(1198373);
   localparam logic [RECIP_WIDTH-1:0]  RECIP_FIVE  = RECIP_WIDTH'(1677722);

   // Index codes with fixed meaning (codes 6 and 7 only when e0 <= e1)
   localparam logic [INDEX_WIDTH-1:0] IDX_ENDPOINT0 = 3'd0;
   localparam logic [INDEX_WIDTH-1:0] IDX_ENDPOINT1 = 3'd1;
   localparam logic [INDEX_WIDTH-1:0] IDX_ZERO      = 3'd6;
   localparam logic [INDEX_WIDTH-1:0] IDX_ONE       = 3'd7;

   // Configuration port
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DUAL_MODE = 1'b0;

   typedef struct packed {
      logic dual_channel_mode;
   } bc45_cfg_type;

endpackage

// File: hw/rtl/bc45_csr.sv
// ----------------------------------------------------------------------------
// BC4/BC5 configuration registers
// APB-style register file holding the channel mode.
// ----------------------------------------------------------------------------
module bc45_csr
   import bc45_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output bc45_cfg_type              cfg
);

   logic                       dual_mode_ff;
   logic                       dual_mode_in;
   logic [CSR_INDEX_WIDTH-1:0] reg_index;
   logic                       write_strobe;

   assign reg_index    = paddr[CSR_ADDR_WIDTH-1 -: CSR_INDEX_WIDTH];
   assign write_strobe = psel && penable && pwrite;
   assign pready       = 1'b1;

   always_comb begin
      dual_mode_in = dual_mode_ff;
      if (write_strobe && reg_index == CSR_DUAL_MODE) begin
         dual_mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dual_mode_ff <= 1'b0;
      end else begin
         dual_mode_ff <= dual_mode_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == CSR_DUAL_MODE) begin
         prdata[0] = dual_mode_ff;
      end
   end

   assign cfg.dual_channel_mode = dual_mode_ff;

endmodule

// File: hw/rtl/bc45_lane.sv
// ----------------------------------------------------------------------------
// BC4/BC5 channel lane
// Decodes one texel of one 64-bit block to a Q0.16 value.
// ----------------------------------------------------------------------------
module bc45_lane
   import bc45_pkg::*;
(
   input  logic [BLOCK_WIDTH-1:0] block,
   input  logic [COORD_WIDTH-1:0] texel_column,
   input  logic [COORD_WIDTH-1:0] texel_row,
   output logic [VALUE_WIDTH-1:0] value
);

   logic [ENDPOINT_WIDTH-1:0]                e0;
   logic [ENDPOINT_WIDTH-1:0]                e1;
   logic [TEXEL_COUNT-1:0][INDEX_WIDTH-1:0]  indices;
   logic [INDEX_WIDTH-1:0]                   idx;
   logic                                     seven_step;
   logic [INDEX_WIDTH:0]                     w0_wide;
   logic [INDEX_WIDTH-1:0]                   w0;
   logic [INDEX_WIDTH-1:0]                   w1;
   logic [SUM_WIDTH-1:0]                     blend_sum;
   logic [SCALED_WIDTH-1:0]                  scaled;
   logic [RECIP_WIDTH-1:0]                   recip;
   logic [PROD_WIDTH-1:0]                    product;
   logic [VALUE_WIDTH-1:0]                   quotient;

   assign e0      = block[ENDPOINT_WIDTH-1:0];
   assign e1      = block[2*ENDPOINT_WIDTH-1:ENDPOINT_WIDTH];
   assign indices = block[BLOCK_WIDTH-1:2*ENDPOINT_WIDTH];
   assign idx     = indices[{texel_row, texel_column}];

   assign seven_step = e0 > e1;

   // Endpoint weights of the blend
   assign w0_wide = seven_step ? (4'd8 - {1'b0, idx}) : (4'd6 - {1'b0, idx});
   assign w0      = w0_wide[INDEX_WIDTH-1:0];
   assign w1      = idx - 3'd1;

   assign blend_sum = SUM_WIDTH'(w0) * SUM_WIDTH'(e0) + SUM_WIDTH'(w1) * SUM_WIDTH'(e1);

   // Round half up: floor((2*257*sum + d) / (2*d)) by reciprocal multiply
   assign scaled   = SCALED_WIDTH'(blend_sum) * BLEND_SCALE
                     + (seven_step ? DIV_SEVEN : DIV_FIVE);
   assign recip    = seven_step ? RECIP_SEVEN : RECIP_FIVE;
   assign product  = PROD_WIDTH'(scaled) * PROD_WIDTH'(recip);
   assign quotient = product[RECIP_SHIFT +: VALUE_WIDTH];

   always_comb begin
      case (idx)
         IDX_ENDPOINT0: value = {e0, e0};
         IDX_ENDPOINT1: value = {e1, e1};
         IDX_ZERO:      value = seven_step ? quotient : '0;
         IDX_ONE:       value = seven_step ? quotient : '1;
         default:       value = quotient;
      endcase
   end

endmodule

// File: hw/rtl/bc4_bc5_texel_decode.sv
// ----------------------------------------------------------------------------
// BC4/BC5 texel decode
// Decodes one texel from one (BC4) or two (BC5) compressed blocks per word.
// ----------------------------------------------------------------------------
// The block takes one request word per cycle while req_stall is low and returns
// one response word per request, in order. A request word is captured in an
// input register; the two channel lanes decode it from there into the response
// register, which presents the response word on rsp_first_value and
// rsp_second_value. Throughput is one texel per cycle while rsp_stall is low,
// set by the input and response registers each turning over once a cycle.
// Stall on the response side backs up through the response register into the
// input register and only then reaches req_stall, so a word is taken while a
// finished response still waits. In single-channel mode rsp_second_value
// repeats rsp_first_value and req_second_block is ignored. Write the mode
// register (byte address 0, bit 0) only while no response is outstanding.
// ----------------------------------------------------------------------------
module bc4_bc5_texel_decode
   import bc45_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [BLOCK_WIDTH-1:0]    req_first_block,
   input  logic [BLOCK_WIDTH-1:0]    req_second_block,
   input  logic [COORD_WIDTH-1:0]    req_texel_column,
   input  logic [COORD_WIDTH-1:0]    req_texel_row,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [VALUE_WIDTH-1:0]    rsp_first_value,
   output logic [VALUE_WIDTH-1:0]    rsp_second_value,

   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   bc45_cfg_type cfg;

   // Input register
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [BLOCK_WIDTH-1:0] s1_first_block_ff;
   logic [BLOCK_WIDTH-1:0] s1_second_block_ff;
   logic [COORD_WIDTH-1:0] s1_column_ff;
   logic [COORD_WIDTH-1:0] s1_row_ff;

   // Response register
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_first_ff;
   logic [VALUE_WIDTH-1:0] rsp_second_ff;

   logic                   rsp_advance;
   logic                   s1_advance;
   logic                   req_take;
   logic [VALUE_WIDTH-1:0] first_decoded;
   logic [VALUE_WIDTH-1:0] second_decoded;

   bc45_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Handshake: advance the response register when it is empty or drained,
   // advance the input register when it is empty or moves on.
   assign rsp_advance = !rsp_valid_ff || !rsp_stall;
   assign s1_advance  = !s1_valid_ff || rsp_advance;
   assign req_stall   = !s1_advance;
   assign req_take    = req_valid && s1_advance;

   assign s1_valid_in  = s1_advance ? req_valid : s1_valid_ff;
   assign rsp_valid_in = rsp_advance ? s1_valid_ff : rsp_valid_ff;

   // Decode both channels from the input register
   bc45_lane u_lane_first (
      .block        (s1_first_block_ff),
      .texel_column (s1_column_ff),
      .texel_row    (s1_row_ff),
      .value        (first_decoded)
   );

   bc45_lane u_lane_second (
      .block        (s1_second_block_ff),
      .texel_column (s1_column_ff),
      .texel_row    (s1_row_ff),
      .value        (second_decoded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_first_block_ff  <= req_first_block;
         s1_second_block_ff <= req_second_block;
         s1_column_ff       <= req_texel_column;
         s1_row_ff          <= req_texel_row;
      end
   end

   // Load the response word; single-channel mode repeats the first value
   always_ff @(posedge clock) begin
      if (rsp_advance && s1_valid_ff) begin
         rsp_first_ff  <= first_decoded;
         rsp_second_ff <= cfg.dual_channel_mode ? second_decoded : first_decoded;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_value  = rsp_first_ff;
   assign rsp_second_value = rsp_second_ff;

`ifndef SYNTHESIS
   // A taken request word always lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted request word not captured");

   // A drained response with nothing behind it leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !s1_valid_ff) |=> !rsp_valid)
      else $error("response word repeated");

   // Single-channel mode copies the first value into the second
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !cfg.dual_channel_mode) |-> (rsp_second_value == rsp_first_value))
      else $error("single-channel second value differs from first");
`endif

endmodule
